// ===== rtl/core/hhl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hhl_pkg
// Shared constants, types and command/status structs for the Huber hinge
// loss gradient block.
// ----------------------------------------------------------------------------
package hhl_pkg;

  // fixed point format of prediction and gradient
  localparam int FRAC_BITS   = 16;
  localparam int VALUE_WIDTH = 24;

  // register and result widths
  localparam int HW_W       = 23;
  localparam int RECIP_W    = 31;
  localparam int LOSS_W     = 47;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // datapath widths
  localparam int M_W        = VALUE_WIDTH + 2;
  localparam int CMP_W      = ((M_W > HW_W + 2) ? M_W : HW_W + 2) + 1;
  localparam int T_W        = HW_W + 1;
  localparam int PROD_W     = T_W + RECIP_W;
  localparam int Q_W        = 39;
  localparam int Q_LO_W     = 20;
  localparam int Q_HI_W     = Q_W - Q_LO_W;
  localparam int LO_PROD_W  = T_W + Q_LO_W;
  localparam int HI_PROD_W  = T_W + Q_HI_W;
  localparam int FULL_W     = T_W + Q_W;

  // reset values of the configuration registers
  localparam logic [HW_W-1:0]    HW_RESET    = HW_W'(655);
  localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(3276800);

  localparam logic [LOSS_W-1:0] LOSS_MAX = {LOSS_W{1'b1}};
  localparam logic [Q_W-1:0]    Q_CAP    = {Q_W{1'b1}};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_WIDTH      = 2'd0,
    CFG_RECIP_TWO_WIDTH = 2'd1
  } hhl_cfg_idx_t;

  // margin region of one example
  typedef enum logic [1:0] {
    REG_FLAT   = 2'b00,
    REG_LINEAR = 2'b01,
    REG_QUAD   = 2'b10
  } hhl_region_t;

  // controller to datapath commands
  typedef struct packed {
    logic ld_in;
    logic ld_region;
    logic mul_q;
    logic mul_lo;
    logic mul_hi;
    logic ld_sum;
    logic finish;
  } hhl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic quad;
    logic out_free;
  } hhl_sts_t;

endpackage : hhl_pkg
`default_nettype wire

// ===== rtl/core/hhl_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hhl_if
// Valid/ready channel interfaces: example input, result output and
// configuration write.
// ----------------------------------------------------------------------------

// example channel
interface hhl_in_if;
  import hhl_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] prediction;
  logic                          label_positive;
  logic                          last_example;

  modport source (output valid, prediction, label_positive, last_example, input ready);
  modport sink   (input valid, prediction, label_positive, last_example, output ready);
endinterface : hhl_in_if

// result channel
interface hhl_out_if;
  import hhl_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] gradient;
  logic        [LOSS_W-1:0]      loss_total;
  logic                          batch_done;

  modport source (output valid, gradient, loss_total, batch_done, input ready);
  modport sink   (input valid, gradient, loss_total, batch_done, output ready);
endinterface : hhl_out_if

// configuration write channel
interface hhl_cfg_if;
  import hhl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface : hhl_cfg_if
`default_nettype wire

// ===== rtl/core/hhl_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hhl_datapath
// Margin, region test, shared multiplier, loss accumulator, configuration
// registers and the output register.
// ----------------------------------------------------------------------------
module hhl_datapath import hhl_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hhl_cmd_t                      cmd,
  output hhl_sts_t                      sts,
  input  logic signed [VALUE_WIDTH-1:0] in_prediction,
  input  logic                          in_label_positive,
  input  logic                          in_last_example,
  hhl_cfg_if.sink                       cfg_chan,
  hhl_out_if.source                     out_chan
);

  localparam logic signed [M_W-1:0] ONE_M = M_W'(1) << FRAC_BITS;
  localparam logic [VALUE_WIDTH-1:0] ONE_G = VALUE_WIDTH'(1) << FRAC_BITS;
  localparam logic [Q_W-1:0] NEG_MAG = Q_W'(1) << (VALUE_WIDTH - 1);
  localparam logic [Q_W-1:0] POS_MAG = Q_W'({(VALUE_WIDTH - 1){1'b1}});

  logic [HW_W-1:0]              hw_r;
  logic [RECIP_W-1:0]           recip_r;
  logic signed [M_W-1:0]        v_r;
  logic signed [M_W-1:0]        v_nxt;
  logic signed [M_W-1:0]        f_ext;
  logic                         ypos_r;
  logic                         last_r;
  hhl_region_t                  region_r;
  hhl_region_t                  region_nxt;
  logic signed [CMP_W-1:0]      v_c;
  logic signed [CMP_W-1:0]      h_c;
  logic signed [CMP_W-1:0]      t_c;
  logic                         is_lin;
  logic                         is_flat;
  logic [T_W-1:0]               t_r;
  logic [RECIP_W-1:0]           b_op;
  logic [PROD_W-1:0]            prod_r;
  logic [PROD_W-1:0]            q_full;
  logic [Q_W-1:0]               q_c;
  logic [Q_W-1:0]               q_r;
  logic [LO_PROD_W-1:0]         lo_r;
  logic [FULL_W-1:0]            full_c;
  logic [FULL_W-1:0]            term_full;
  logic [LOSS_W-1:0]            term_r;
  logic [LOSS_W-1:0]            acc_r;
  logic [LOSS_W-1:0]            acc_nxt;
  logic [LOSS_W:0]              sum_c;
  logic [LOSS_W-1:0]            sum_sat;
  logic [Q_W-1:0]               mag_c;
  logic [VALUE_WIDTH-1:0]       grad_c;
  logic                         out_valid_r;
  logic signed [VALUE_WIDTH-1:0] out_grad_r;
  logic [LOSS_W-1:0]            out_loss_r;
  logic                         out_done_r;

  // configuration registers, unknown indexes are dropped
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r    <= HW_RESET;
      recip_r <= RECIP_RESET;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      case (hhl_cfg_idx_t'(cfg_chan.index))
        CFG_HALF_WIDTH:      hw_r    <= cfg_chan.data[HW_W-1:0];
        CFG_RECIP_TWO_WIDTH: recip_r <= cfg_chan.data[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // margin v = 1 - y*f
  always_comb begin
    f_ext = M_W'(in_prediction);
    v_nxt = in_label_positive ? (ONE_M - f_ext) : (ONE_M + f_ext);
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      v_r    <= v_nxt;
      ypos_r <= in_label_positive;
      last_r <= in_last_example;
    end
  end

  // region test and t = v + h
  always_comb begin
    v_c     = CMP_W'(v_r);
    h_c     = signed'(CMP_W'(hw_r));
    t_c     = v_c + h_c;
    is_lin  = v_c > h_c;
    is_flat = v_c < -h_c;
    if (is_lin) begin
      region_nxt = REG_LINEAR;
    end else if (is_flat) begin
      region_nxt = REG_FLAT;
    end else begin
      region_nxt = REG_QUAD;
    end
  end

  assign sts.quad     = !is_lin && !is_flat;
  assign sts.out_free = !out_valid_r || out_chan.ready;

  // quotient q = (t * recip) >> FRAC_BITS, capped
  always_comb begin
    q_full = prod_r >> FRAC_BITS;
    q_c    = (q_full > PROD_W'(Q_CAP)) ? Q_CAP : q_full[Q_W-1:0];
  end

  // shared multiplier operand select
  always_comb begin
    b_op = recip_r;
    if (cmd.mul_lo) begin
      b_op = RECIP_W'(q_c[Q_LO_W-1:0]);
    end else if (cmd.mul_hi) begin
      b_op = RECIP_W'(q_r[Q_W-1:Q_LO_W]);
    end
  end

  // loss term (t * q) >> (FRAC_BITS + 1) from two partial products
  always_comb begin
    full_c    = (FULL_W'(prod_r[HI_PROD_W-1:0]) << Q_LO_W) + FULL_W'(lo_r);
    term_full = full_c >> (FRAC_BITS + 1);
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_region) begin
      region_r <= region_nxt;
      t_r      <= t_c[T_W-1:0];
      term_r   <= is_lin ? LOSS_W'($unsigned(v_r)) : '0;
    end else if (cmd.ld_sum) begin
      term_r   <= (term_full > FULL_W'(LOSS_MAX)) ? LOSS_MAX : term_full[LOSS_W-1:0];
    end
    if (cmd.mul_q || cmd.mul_lo || cmd.mul_hi) begin
      prod_r <= PROD_W'(t_r) * PROD_W'(b_op);
    end
    if (cmd.mul_lo) begin
      q_r <= q_c;
    end
    if (cmd.mul_hi) begin
      lo_r <= prod_r[LO_PROD_W-1:0];
    end
  end

  // saturating accumulate
  always_comb begin
    sum_c   = {1'b0, acc_r} + {1'b0, term_r};
    sum_sat = sum_c[LOSS_W] ? LOSS_MAX : sum_c[LOSS_W-1:0];
    acc_nxt = last_r ? '0 : sum_sat;
  end

  // gradient by region, saturated to the signed value range
  always_comb begin
    mag_c  = '0;
    grad_c = '0;
    case (region_r)
      REG_FLAT: begin
        grad_c = '0;
      end
      REG_LINEAR: begin
        grad_c = ypos_r ? -ONE_G : ONE_G;
      end
      REG_QUAD: begin
        if (ypos_r) begin
          mag_c  = (q_r > NEG_MAG) ? NEG_MAG : q_r;
          grad_c = -mag_c[VALUE_WIDTH-1:0];
        end else begin
          mag_c  = (q_r > POS_MAG) ? POS_MAG : q_r;
          grad_c = mag_c[VALUE_WIDTH-1:0];
        end
      end
      default: begin
        grad_c = '0;
      end
    endcase
  end

  // accumulator and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      acc_r       <= acc_nxt;
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_grad_r <= signed'(grad_c);
      out_loss_r <= last_r ? sum_sat : '0;
      out_done_r <= last_r;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.gradient   = out_grad_r;
  assign out_chan.loss_total = out_loss_r;
  assign out_chan.batch_done = out_done_r;

endmodule : hhl_datapath
`default_nettype wire

// ===== rtl/core/hhl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hhl_ctrl
// Sequencer that steps one example through margin, region test, the three
// multiplier passes (quadratic region only) and the accumulate.
// ----------------------------------------------------------------------------
module hhl_ctrl import hhl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  hhl_sts_t sts,
  output hhl_cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_REGION = 7'b0000010,
    ST_MUL_Q  = 7'b0000100,
    ST_MUL_LO = 7'b0001000,
    ST_MUL_HI = 7'b0010000,
    ST_SUM    = 7'b0100000,
    ST_ACC    = 7'b1000000
  } hhl_state_t;

  hhl_state_t state_r;
  hhl_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = ST_REGION;
        end
      end
      ST_REGION: begin
        cmd.ld_region = 1'b1;
        state_nxt     = sts.quad ? ST_MUL_Q : ST_ACC;
      end
      ST_MUL_Q: begin
        cmd.mul_q = 1'b1;
        state_nxt = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        cmd.ld_sum = 1'b1;
        state_nxt  = ST_ACC;
      end
      ST_ACC: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule : hhl_ctrl
`default_nettype wire

// ===== rtl/core/huber_hinge_loss_grad.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// huber_hinge_loss_grad
// Huber-smoothed hinge loss: per-example gradient and batch loss sum.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan takes one example per transaction (prediction, label, last flag).
//   out_chan returns one result per example: the gradient, and on the last
//   example of a batch the saturated loss sum with batch_done set (the sum
//   is then cleared). cfg_chan writes half_width (index 0) and
//   recip_two_width (index 1) and is always ready; write it only while idle.
// Sequence (a new example is accepted only once the last one is done):
//   flat and linear region: accept, region test, accumulate. Quadratic
//   region: accept, region test, three multiplier passes, sum, accumulate.
//   One shared 24x31 multiplier runs three passes per quadratic example
//   (quotient, then the loss product in two halves).
// Reset: synchronous rst_n clears the sequencer, the loss sum and the
//   output valid, and loads h = 655 and 1/(2h) = 3276800.
// Stall: a finished result waits in the output register while the next
//   example is accepted and processed; that one holds before its
//   accumulate step until the output register is taken.
// ----------------------------------------------------------------------------
module huber_hinge_loss_grad import hhl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  hhl_in_if.sink    in_chan,
  hhl_out_if.source out_chan,
  hhl_cfg_if.sink   cfg_chan
);

  hhl_cmd_t cmd;
  hhl_sts_t sts;
  logic     in_ready;

  assign in_chan.ready = in_ready;

  // sequencer
  hhl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and storage
  hhl_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_prediction     (in_chan.prediction),
    .in_label_positive (in_chan.label_positive),
    .in_last_example   (in_chan.last_example),
    .cfg_chan          (cfg_chan),
    .out_chan          (out_chan)
  );

endmodule : huber_hinge_loss_grad
`default_nettype wire

// ===== rtl/core/hhl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hhl_checker
// Port-level checks of the loss gradient block, bound to the top level.
// ----------------------------------------------------------------------------
module hhl_checker import hhl_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [VALUE_WIDTH-1:0] gradient,
  input logic [LOSS_W-1:0]      loss_total,
  input logic                   batch_done
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(gradient) &&
    $stable(loss_total) && $stable(batch_done))
    else $error("stalled result changed");

  // loss sum shows only with batch_done
  a_loss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !batch_done |-> loss_total == '0)
    else $error("loss_total nonzero outside batch end");

  // one example at a time: no acceptance right after an acceptance
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // no result appears the cycle after acceptance into an empty block
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule : hhl_checker

bind huber_hinge_loss_grad hhl_checker u_hhl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .gradient   (out_chan.gradient),
  .loss_total (out_chan.loss_total),
  .batch_done (out_chan.batch_done)
);
`default_nettype wire
